### hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define GSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define GSC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/gsc_pkg.sv
package gsc_pkg;

    localparam int KIND_W      = 2;
    localparam int COLUMN_W    = 6;
    localparam int VALUE_W     = 2;
    localparam int SCORE_W     = 10;
    localparam int THR_W       = 10;
    localparam int OUT_FIELD_W = 24;
    localparam int IN_USER_W   = 3;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 48;
    localparam int COLUMN_CODES = 64;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               last;
        logic               case_flag;
        logic               in_range;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] ref_value;
    } t_elem;

endpackage

### hdl/gsc_tally.sv
module gsc_tally #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gsc_pkg::THR_W-1:0]     i_cfg_wdata,
    input  logic                          i_en,
    input  gsc_pkg::t_elem                i_elem,
    output logic [COUNT_WIDTH-1:0]        o_cases,
    output logic [COUNT_WIDTH-1:0]        o_controls
);

    `include "assert_macros.svh"

    logic [gsc_pkg::THR_W-1:0]    r_thr;
    logic [gsc_pkg::SCORE_W-1:0]  r_score;
    logic [gsc_pkg::SCORE_W-1:0]  n_score;
    logic [COUNT_WIDTH-1:0]       r_cases;
    logic [COUNT_WIDTH-1:0]       n_cases;
    logic [COUNT_WIDTH-1:0]       r_controls;
    logic [COUNT_WIDTH-1:0]       n_controls;

    logic [gsc_pkg::VALUE_W-1:0]  diff;
    logic [3:0]                   sq;
    logic [gsc_pkg::SCORE_W:0]    sum;
    logic [gsc_pkg::SCORE_W-1:0]  sat_score;
    logic [gsc_pkg::SCORE_W-1:0]  cur_score;
    logic                         hit;

    assign diff = (i_elem.value >= i_elem.ref_value) ? i_elem.value - i_elem.ref_value
                                                     : i_elem.ref_value - i_elem.value;
    assign sq        = 4'(diff) * 4'(diff);
    assign sum       = (gsc_pkg::SCORE_W+1)'(r_score) + (gsc_pkg::SCORE_W+1)'(sq);
    assign sat_score = sum[gsc_pkg::SCORE_W] ? '1 : sum[gsc_pkg::SCORE_W-1:0];
    assign cur_score = i_elem.in_range ? sat_score : r_score;
    assign hit       = cur_score < r_thr;

    always_comb begin
        n_score    = r_score;
        n_cases    = r_cases;
        n_controls = r_controls;
        if (i_en) begin
            case (i_elem.kind)
                gsc_pkg::KIND_ROW: begin
                    if (i_elem.last) begin
                        n_score = '0;
                        if (hit) begin
                            if (i_elem.case_flag) begin
                                n_cases = (&r_cases) ? r_cases : r_cases + 1'b1;
                            end else begin
                                n_controls = (&r_controls) ? r_controls : r_controls + 1'b1;
                            end
                        end
                    end else begin
                        n_score = cur_score;
                    end
                end
                gsc_pkg::KIND_REPORT: begin
                    n_cases    = '0;
                    n_controls = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= '0;
            r_score    <= '0;
            r_cases    <= '0;
            r_controls <= '0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_score    <= n_score;
            r_cases    <= n_cases;
            r_controls <= n_controls;
        end
    end

    assign o_cases    = r_cases;
    assign o_controls = r_controls;

    `GSC_ASSERT(a_report_clears,
        i_en && (i_elem.kind == gsc_pkg::KIND_REPORT) |=> (r_cases == '0) && (r_controls == '0),
        "counters not cleared after report")
    `GSC_ASSERT(a_row_end_clears_score,
        i_en && (i_elem.kind == gsc_pkg::KIND_ROW) && i_elem.last |=> (r_score == '0),
        "row score not cleared at end of row")

endmodule

### hdl/genotype_similarity_count_top.sv
// channel   dir  handshake                         payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready tdata {value, column}, tuser {case_flag, kind},
//                                                  tlast last_of_row
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready tdata {control_count, case_count}
// cfg       in   i_cfg_we                          i_cfg_wdata distance_threshold
//
// one item per cycle unless a report is held in the scoring stage; the reference store read is
// registered with the item, and the score, compare and counter update work on that stage
// a report is registered in the scoring stage, then in the output register behind o_m_axis_tvalid
// a report waiting for a full output register holds the scoring stage and stalls input
// i_rst_n is synchronous, active low; o_s_axis_tready is low during reset, and the
// reference store is not cleared by it
module genotype_similarity_count_top #(
    parameter int MAX_COLUMNS = 64,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [gsc_pkg::THR_W-1:0]          i_cfg_wdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [gsc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // column, value
    input  logic [gsc_pkg::IN_USER_W-1:0]      i_s_axis_tuser,  // kind, case_flag
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [gsc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata   // case_count, control_count
);

    `include "assert_macros.svh"

    localparam int DEPTH = (MAX_COLUMNS < gsc_pkg::COLUMN_CODES) ? MAX_COLUMNS
                                                                  : gsc_pkg::COLUMN_CODES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [gsc_pkg::KIND_W-1:0]   in_kind;
    logic [gsc_pkg::COLUMN_W-1:0] in_column;
    logic [gsc_pkg::VALUE_W-1:0]  in_value;
    logic [15:0]                  col_ext;
    logic [AW-1:0]                idx;
    logic                         in_range;
    logic                         s_acc;
    logic                         s1_go;
    logic                         out_free;
    logic                         s1_report;

    logic [gsc_pkg::VALUE_W-1:0]  r_ref_mem [DEPTH];
    logic [gsc_pkg::VALUE_W-1:0]  r_ref;
    logic                         r_s1_valid;
    logic                         n_s1_valid;
    logic [gsc_pkg::KIND_W-1:0]   r_s1_kind;
    logic                         r_s1_last;
    logic                         r_s1_case;
    logic                         r_s1_in_range;
    logic [gsc_pkg::VALUE_W-1:0]  r_s1_value;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [gsc_pkg::OUT_FIELD_W-1:0] r_out_with;
    logic [gsc_pkg::OUT_FIELD_W-1:0] r_out_without;

    gsc_pkg::t_elem               elem;
    logic [COUNT_WIDTH-1:0]       cases;
    logic [COUNT_WIDTH-1:0]       controls;
    logic [31:0]                  cases_ext;
    logic [31:0]                  controls_ext;

    assign in_kind   = i_s_axis_tuser[gsc_pkg::KIND_W-1:0];
    assign in_column = i_s_axis_tdata[gsc_pkg::COLUMN_W-1:0];
    assign in_value  = i_s_axis_tdata[gsc_pkg::COLUMN_W +: gsc_pkg::VALUE_W];
    assign col_ext   = 16'(in_column);
    assign idx       = col_ext[AW-1:0];
    assign in_range  = col_ext < 16'(MAX_COLUMNS);

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_report       = r_s1_kind == gsc_pkg::KIND_REPORT;
    assign s1_go           = r_s1_valid && (!s1_report || out_free);
    assign o_s_axis_tready = i_rst_n && (!r_s1_valid || s1_go);
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // reference store, read registered alongside the item
    always_ff @(posedge i_clk) begin
        if (s_acc && (in_kind == gsc_pkg::KIND_LOAD) && in_range) begin
            r_ref_mem[idx] <= in_value;
        end
        if (s_acc) begin
            r_ref <= r_ref_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_kind     <= in_kind;
            r_s1_last     <= i_s_axis_tlast;
            r_s1_case     <= i_s_axis_tuser[gsc_pkg::KIND_W];
            r_s1_in_range <= in_range;
            r_s1_value    <= in_value;
        end
    end

    assign n_s1_valid  = s_acc || (r_s1_valid && !s1_go);
    assign n_out_valid = (s1_go && s1_report) || (r_out_valid && !i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign elem.kind      = r_s1_kind;
    assign elem.last      = r_s1_last;
    assign elem.case_flag = r_s1_case;
    assign elem.in_range  = r_s1_in_range;
    assign elem.value     = r_s1_value;
    assign elem.ref_value = r_ref;

    gsc_tally #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_tally (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_en        (s1_go),
        .i_elem      (elem),
        .o_cases     (cases),
        .o_controls  (controls)
    );

    assign cases_ext    = 32'(cases);
    assign controls_ext = 32'(controls);

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_report) begin
            r_out_with    <= cases_ext[gsc_pkg::OUT_FIELD_W-1:0];
            r_out_without <= controls_ext[gsc_pkg::OUT_FIELD_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_without, r_out_with};

    `GSC_ASSERT(a_report_held,
        r_s1_valid && s1_report && !out_free |=> r_s1_valid,
        "stalled report dropped from scoring stage")
    `GSC_ASSERT(a_report_to_out,
        s1_go && s1_report |=> r_out_valid,
        "report did not reach output register")
    `GSC_ASSERT_ALWAYS(a_no_overwrite,
        !(s_acc && r_s1_valid && !s1_go),
        "item accepted over a held item")
    `GSC_ASSERT(a_out_only_from_report,
        !$past(r_out_valid) && r_out_valid |-> $past(s1_go && s1_report),
        "result appeared without a report")

endmodule

### bench/tb_genotype_similarity_count_top.sv
`timescale 1ns / 100ps

module tb_genotype_similarity_count_top;

    localparam logic [gsc_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned SCORE_CAP = (1 << gsc_pkg::SCORE_W) - 1;
    localparam logic [gsc_pkg::OUT_FIELD_W-1:0] COUNT_CAP = '1;
    localparam int PHASES = 8;
    localparam int RANDOM_ITEMS = 800;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [gsc_pkg::KIND_W-1:0]   kind;
        logic [gsc_pkg::COLUMN_W-1:0] column;
        logic [gsc_pkg::VALUE_W-1:0]  value;
        logic                         last;
        logic                         case_flag;
    } t_geno_item;

    typedef struct packed {
        logic [gsc_pkg::OUT_FIELD_W-1:0] controls;
        logic [gsc_pkg::OUT_FIELD_W-1:0] cases;
    } t_count_pair;

    typedef struct packed {
        logic                       is_cfg;
        logic [gsc_pkg::THR_W-1:0]  thr;
        logic                       typed;
        t_count_pair                counts;
        t_geno_item                 item;
    } t_plan_step;

    localparam int ITEM_W = $bits(t_geno_item);

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [gsc_pkg::THR_W-1:0]       i_cfg_wdata = '0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [gsc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata = '0;  // column, value
    logic [gsc_pkg::IN_USER_W-1:0]   i_s_axis_tuser = '0;  // kind, case_flag
    logic                            i_s_axis_tlast = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b1;
    logic [gsc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;       // case_count, control_count

    // similarity predictor state
    logic [gsc_pkg::VALUE_W-1:0]     ref_genotype [gsc_pkg::COLUMN_CODES];
    int unsigned                     row_dist = 0;
    logic [gsc_pkg::THR_W-1:0]       dist_limit = '0;
    logic [gsc_pkg::OUT_FIELD_W-1:0] n_case_hits = '0;
    logic [gsc_pkg::OUT_FIELD_W-1:0] n_control_hits = '0;

    t_count_pair report_q [$];
    t_plan_step  plan [$];
    t_count_pair seen_counts;
    t_count_pair want_counts;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int errors = 0;
    int n_items = 0;
    int n_reports = 0;
    int n_hits = 0;
    int n_saturated = 0;
    int n_settings = 0;

    genotype_similarity_count_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("tb_genotype_similarity_count_top NOT OK");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen_counts = o_m_axis_tdata;
            if (report_q.size() == 0) begin
                $error("count report with none pending: case_count %0d control_count %0d",
                       seen_counts.cases, seen_counts.controls);
                errors++;
            end else begin
                want_counts = report_q.pop_front();
                if (seen_counts.cases !== want_counts.cases) begin
                    $error("case_count expected %0d actual %0d",
                           want_counts.cases, seen_counts.cases);
                    errors++;
                end
                if (seen_counts.controls !== want_counts.controls) begin
                    $error("control_count expected %0d actual %0d",
                           want_counts.controls, seen_counts.controls);
                    errors++;
                end
            end
        end
    end

    function automatic bit predict_counts(input t_geno_item it, output t_count_pair res);
        int unsigned r;
        int unsigned v;
        int unsigned d;
        int unsigned s;
        res = '0;
        case (it.kind)
            gsc_pkg::KIND_LOAD: ref_genotype[it.column] = it.value;
            gsc_pkg::KIND_ROW: begin
                r = 32'(ref_genotype[it.column]);
                v = 32'(it.value);
                d = (v >= r) ? v - r : r - v;
                s = row_dist + d * d;
                row_dist = (s > SCORE_CAP) ? SCORE_CAP : s;
                if (it.last) begin
                    if (row_dist == SCORE_CAP) n_saturated++;
                    if (row_dist < 32'(dist_limit)) begin
                        n_hits++;
                        if (it.case_flag) begin
                            if (n_case_hits != COUNT_CAP) n_case_hits++;
                        end else begin
                            if (n_control_hits != COUNT_CAP) n_control_hits++;
                        end
                    end
                    row_dist = 0;
                end
            end
            gsc_pkg::KIND_REPORT: begin
                res.cases = n_case_hits;
                res.controls = n_control_hits;
                n_case_hits = '0;
                n_control_hits = '0;
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void plan_item(logic [gsc_pkg::KIND_W-1:0] k, int col, int val, bit last,
                                      bit cf, bit typed, int exp_cases, int exp_controls);
        t_plan_step s;
        s = '0;
        s.item.kind = k;
        s.item.column = col[gsc_pkg::COLUMN_W-1:0];
        s.item.value = val[gsc_pkg::VALUE_W-1:0];
        s.item.last = last;
        s.item.case_flag = cf;
        s.typed = typed;
        s.counts.cases = exp_cases[gsc_pkg::OUT_FIELD_W-1:0];
        s.counts.controls = exp_controls[gsc_pkg::OUT_FIELD_W-1:0];
        plan.push_back(s);
    endfunction

    function automatic void plan_thr(int t);
        t_plan_step s;
        s = '0;
        s.is_cfg = 1'b1;
        s.thr = t[gsc_pkg::THR_W-1:0];
        plan.push_back(s);
    endfunction

    task automatic push_item(input t_geno_item it, input bit typed,
                             input t_count_pair typed_counts);
        t_count_pair res;
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata = {it.value, it.column};
        i_s_axis_tuser = {it.case_flag, it.kind};
        i_s_axis_tlast = it.last;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n_items++;
        if (predict_counts(it, res)) begin
            n_reports++;
            report_q.push_back(typed ? typed_counts : res);
        end
    endtask

    task automatic settle_and_write(input logic [gsc_pkg::THR_W-1:0] t);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_wdata = t;
        i_cfg_we = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        dist_limit = t;
        n_settings++;
    endtask

    task automatic run_phase(input int budget);
        int made;
        int pick;
        int n;
        int c;
        t_geno_item it;
        made = 0;
        while (made < budget) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    it = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
                    it.kind = gsc_pkg::KIND_ROW;
                    it.last = (i == n - 1);
                    push_item(it, 1'b0, '0);
                    made++;
                end
            end else if (pick < 64) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    it = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
                    it.kind = gsc_pkg::KIND_LOAD;
                    push_item(it, 1'b0, '0);
                    made++;
                end
            end else if (pick < 79) begin
                it = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
                it.kind = gsc_pkg::KIND_REPORT;
                push_item(it, 1'b0, '0);
                made++;
            end else if (pick < 97) begin
                it = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
                push_item(it, 1'b0, '0);
                if (it.kind != KIND_UNUSED) made++;
            end else begin
                // long row of large distances drives the score into saturation
                it = '0;
                it.kind = gsc_pkg::KIND_LOAD;
                push_item(it, 1'b0, '0);
                made++;
                n = $urandom_range(115, 130);
                for (int i = 0; i < n; i++) begin
                    c = $urandom_range(0, gsc_pkg::COLUMN_CODES - 1);
                    it = '0;
                    it.kind = gsc_pkg::KIND_ROW;
                    if (ref_genotype[c] == 2'd0) begin
                        it.column = c[gsc_pkg::COLUMN_W-1:0];
                        it.value = 2'd3;
                    end else if (ref_genotype[c] == 2'd3) begin
                        it.column = c[gsc_pkg::COLUMN_W-1:0];
                        it.value = 2'd0;
                    end else begin
                        it.value = 2'd3;
                    end
                    it.last = (i == n - 1);
                    it.case_flag = 1'($urandom_range(1));
                    push_item(it, 1'b0, '0);
                    made++;
                end
            end
        end
    endtask

    initial begin
        t_geno_item it;
        logic [gsc_pkg::THR_W-1:0] thr;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        //        kind                  col val last case typed with without
        plan_item(gsc_pkg::KIND_REPORT,  0, 0, 0, 0, 1, 0, 0);
        plan_item(gsc_pkg::KIND_LOAD,    0, 0, 0, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_LOAD,   63, 3, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,     0, 3, 0, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,    63, 0, 1, 1, 0, 0, 0);
        plan_item(KIND_UNUSED,          42, 2, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_REPORT,  0, 0, 0, 0, 1, 0, 0);
        plan_thr(1023);
        plan_item(gsc_pkg::KIND_ROW,     0, 0, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,    63, 3, 1, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,     0, 1, 0, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_REPORT,  0, 0, 0, 0, 1, 1, 1);
        plan_item(gsc_pkg::KIND_ROW,    63, 1, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_REPORT, 63, 3, 1, 1, 1, 1, 0);
        plan_thr(5);
        plan_item(gsc_pkg::KIND_ROW,     0, 2, 0, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,     0, 1, 1, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,     0, 2, 1, 0, 0, 0, 0);
        plan_item(gsc_pkg::KIND_LOAD,   42, 2, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_ROW,    42, 0, 1, 1, 0, 0, 0);
        plan_item(gsc_pkg::KIND_REPORT,  0, 0, 0, 0, 1, 1, 1);

        src_idle_pct = 18;
        sink_stall_pct = 18;
        foreach (plan[k]) begin
            if (plan[k].is_cfg) settle_and_write(plan[k].thr);
            else push_item(plan[k].item, plan[k].typed, plan[k].counts);
        end

        // every column holds a reference value before rows pick columns at random
        for (int c = 0; c < gsc_pkg::COLUMN_CODES; c++) begin
            it = ITEM_W'($urandom_range(0, (1 << ITEM_W) - 1));
            it.kind = gsc_pkg::KIND_LOAD;
            it.column = c[gsc_pkg::COLUMN_W-1:0];
            push_item(it, 1'b0, '0);
        end

        for (int p = 0; p < PHASES; p++) begin
            case ((p / 2) % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 49; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 49; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            case (p % 4)
                0: thr = gsc_pkg::THR_W'($urandom_range(1, 30));
                1: thr = '1;
                2: thr = gsc_pkg::THR_W'($urandom_range(0, 1023));
                default: thr = (p == PHASES - 1) ? '0
                                                 : gsc_pkg::THR_W'($urandom_range(10, 150));
            endcase
            settle_and_write(thr);
            run_phase(RANDOM_ITEMS / PHASES);
        end

        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (report_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("run covered %0d items, %0d count reports, %0d similar rows, %0d saturated rows",
                 n_items, n_reports, n_hits, n_saturated);
        $display("across %0d threshold settings and four handshake pacing modes", n_settings);
        if (errors == 0) begin
            $display("tb_genotype_similarity_count_top OK");
        end else begin
            $display("tb_genotype_similarity_count_top NOT OK");
        end
        $finish;
    end

endmodule
